// ===== rtl/core/pll_pkg.sv =====
// Package: pool geometry, operation and status codes for the linked list engine.
`default_nettype none
package pll_pkg;
   localparam int PoolSize   = 16;
   localparam int ValueWidth = 16;
   localparam int LinkWidth  = $clog2(PoolSize + 1);
   localparam int IdxWidth   = $clog2(PoolSize);
   localparam int CntWidth   = $clog2(PoolSize + 1);
   localparam logic [LinkWidth-1:0] NilLink = LinkWidth'(PoolSize);

   typedef logic [LinkWidth-1:0]         link_type;
   typedef logic [IdxWidth-1:0]          idx_type;
   typedef logic signed [ValueWidth-1:0] value_type;

   typedef enum logic [2:0] {
      OP_INS_HEAD = 3'd0, OP_INS_TAIL = 3'd1, OP_INS_POS = 3'd2,
      OP_INS_SORT = 3'd3, OP_DEL_FIRST = 3'd4, OP_DEL_ALL = 3'd5,
      OP_READ = 3'd6, OP_NONE = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_FULL = 3'd1, ST_NOTFOUND = 3'd2,
      ST_EMPTY = 3'd3, ST_BADPOS = 3'd4
   } status_type;

   // Link store port bundle between sequencer and store.
   typedef struct packed {
      logic     wr_en;
      idx_type  wr_idx;
      link_type wr_link;
      idx_type  rd_idx;
   } link_ctl_type;

   function automatic logic is_valid(link_type l);
      return l < NilLink;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pll_link_store.sv =====
// Link store: per-slot next pointers, reset to a chained free list.
`default_nettype none
module pll_link_store (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pll_pkg::link_ctl_type ctl,
   output pll_pkg::link_type      rd_link
);
   import pll_pkg::*;
   link_type links_ff [PoolSize];

   // Chain slots at reset, else take one write.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PoolSize; i++) links_ff[i] <= LinkWidth'(i + 1);
      end else if (ctl.wr_en) begin
         links_ff[ctl.wr_idx] <= ctl.wr_link;
      end
   end

   assign rd_link = links_ff[ctl.rd_idx];
endmodule
`default_nettype wire

// ===== rtl/core/pll_value_store.sv =====
// Value store: one value per slot, no reset.
`default_nettype none
module pll_value_store (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire pll_pkg::idx_type wr_idx,
   input  wire pll_pkg::value_type wr_value,
   input  wire pll_pkg::idx_type rd_idx,
   output pll_pkg::value_type    rd_value
);
   import pll_pkg::*;
   value_type vals_ff [PoolSize];

   // Write one slot.
   always_ff @(posedge clock) begin
      if (wr_en) vals_ff[wr_idx] <= wr_value;
   end

   assign rd_value = vals_ff[rd_idx];
endmodule
`default_nettype wire

// ===== rtl/core/pooled_linked_list_engine_unit.sv =====
// Top level: sequencer that walks the list one link per cycle, save for relinks.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the item's last result has been shown. Each walk step follows one
// link through the single read port of the link store. A read shows one
// element per cycle. A delete spends an extra relink step (S_FIX) on every
// removal that follows a kept entry. Results appear for one cycle with
// rsp_valid and cannot be stalled.
`default_nettype none
module pooled_linked_list_engine_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [2:0]           req_op,
   input  wire logic signed [15:0]   req_value,
   input  wire logic [4:0]           req_position,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_status,
   output logic signed [15:0]        rsp_element,
   output logic [4:0]                rsp_removed_count,
   output logic                      rsp_last
);
   import pll_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIX} state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   value_type val_ff, val_in;
   logic [4:0] pos_ff, pos_in;
   link_type  head_ff, head_in, free_ff, free_in;
   link_type  prev_ff, prev_in, cur_ff, cur_in;
   logic [CntWidth-1:0] n_ff, n_in, cnt_ff, cnt_in;
   logic      fix_free_ff, fix_free_in;    // second write of an unlink
   idx_type   victim_ff, victim_in;
   logic      ov_in, ov_ff;
   logic [2:0] os_in, os_ff;
   value_type oe_in, oe_ff;
   logic [4:0] oc_in, oc_ff;
   logic      ol_in, ol_ff;

   link_ctl_type lctl;
   link_type  rd_link;
   logic      vwr;
   idx_type   vwr_idx;
   value_type rd_value;

   pll_link_store u_links (.clock, .reset, .ctl(lctl), .rd_link);
   pll_value_store u_vals (.clock, .wr_en(vwr), .wr_idx(vwr_idx),
                           .wr_value(val_ff), .rd_idx(cur_ff[IdxWidth-1:0]),
                           .rd_value);

   logic cur_ok, at_bound;
   assign cur_ok   = is_valid(cur_ff);
   assign at_bound = (n_ff == CntWidth'(PoolSize));

   // Sequence walks, link edits and results.
   always_comb begin
      state_in = state_ff; op_in = op_ff; val_in = val_ff; pos_in = pos_ff;
      head_in = head_ff; free_in = free_ff; prev_in = prev_ff; cur_in = cur_ff;
      n_in = n_ff; cnt_in = cnt_ff; fix_free_in = 1'b0; victim_in = victim_ff;
      ov_in = 1'b0; os_in = ST_OK; oe_in = '0; oc_in = '0; ol_in = 1'b0;
      lctl = '0;
      lctl.rd_idx = cur_ff[IdxWidth-1:0];
      vwr = 1'b0; vwr_idx = free_ff[IdxWidth-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start && !busy) begin
               op_in = op_type'(req_op); val_in = req_value; pos_in = req_position;
               prev_in = NilLink; cur_in = head_ff; n_in = '0; cnt_in = '0;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            case (op_ff)
               OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS, OP_INS_SORT: begin
                  logic stop, bad;
                  stop = 1'b1; bad = 1'b0;
                  if (op_ff == OP_INS_TAIL) stop = !cur_ok || at_bound;
                  else if (op_ff == OP_INS_POS) begin
                     stop = (5'(n_ff) == pos_ff);
                     bad  = !stop && !cur_ok;
                  end else if (op_ff == OP_INS_SORT)
                     stop = !cur_ok || at_bound || !(rd_value < val_ff);
                  if (!is_valid(free_ff)) begin
                     ov_in = 1'b1; os_in = ST_FULL; ol_in = 1'b1; state_in = S_IDLE;
                  end else if (bad) begin
                     ov_in = 1'b1; os_in = ST_BADPOS; ol_in = 1'b1; state_in = S_IDLE;
                  end else if (stop) begin
                     // new slot takes prev's successor; read free's link now
                     lctl.rd_idx = free_ff[IdxWidth-1:0];
                     vwr = 1'b1;
                     free_in = rd_link;
                     lctl.wr_en = 1'b1;
                     lctl.wr_idx = free_ff[IdxWidth-1:0];
                     lctl.wr_link = cur_ff;
                     if (!is_valid(prev_ff)) begin
                        head_in = free_ff;
                        ov_in = 1'b1; ol_in = 1'b1; state_in = S_IDLE;
                     end else begin
                        victim_in = free_ff[IdxWidth-1:0];
                        state_in = S_FIX;
                     end
                  end else begin
                     prev_in = cur_ff; cur_in = rd_link; n_in = n_ff + 1'b1;
                  end
               end
               OP_DEL_FIRST, OP_DEL_ALL: begin
                  if (!cur_ok || at_bound) begin
                     ov_in = 1'b1; ol_in = 1'b1; state_in = S_IDLE;
                     if (op_ff == OP_DEL_ALL) oc_in = 5'(cnt_ff);
                     else os_in = (n_ff == '0) ? ST_EMPTY : ST_NOTFOUND;
                  end else if (rd_value == val_ff) begin
                     // freed slot goes to free head; relink prev next cycle
                     lctl.wr_en = 1'b1; lctl.wr_idx = cur_ff[IdxWidth-1:0];
                     lctl.wr_link = free_ff;
                     free_in = cur_ff;
                     cnt_in = cnt_ff + 1'b1;
                     cur_in = rd_link; n_in = n_ff + 1'b1;
                     if (!is_valid(prev_ff)) begin
                        head_in = rd_link;
                        if (op_ff == OP_DEL_FIRST) begin
                           ov_in = 1'b1; oc_in = 5'd1; ol_in = 1'b1; state_in = S_IDLE;
                        end
                     end else begin
                        fix_free_in = 1'b1;
                        victim_in = prev_ff[IdxWidth-1:0];
                        state_in = S_FIX;
                     end
                  end else begin
                     prev_in = cur_ff; cur_in = rd_link; n_in = n_ff + 1'b1;
                  end
               end
               OP_READ: begin
                  if (!is_valid(head_ff)) begin
                     ov_in = 1'b1; os_in = ST_EMPTY; ol_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     ov_in = 1'b1; oe_in = rd_value;
                     ol_in = !is_valid(rd_link) || (n_ff == CntWidth'(PoolSize - 1));
                     if (ol_in) state_in = S_IDLE;
                     cur_in = rd_link; n_in = n_ff + 1'b1;
                  end
               end
               default: begin
                  ov_in = 1'b1; ol_in = 1'b1; state_in = S_IDLE;
               end
            endcase
         end
         S_FIX: begin
            // link prev to new slot (insert) or to cur (delete)
            lctl.wr_en = 1'b1; lctl.wr_idx = prev_ff[IdxWidth-1:0];
            if (fix_free_ff) begin
               lctl.wr_link = cur_ff;
               if (op_ff == OP_DEL_FIRST) begin
                  ov_in = 1'b1; oc_in = 5'd1; ol_in = 1'b1; state_in = S_IDLE;
               end else state_in = S_WALK;
            end else begin
               lctl.wr_link = {1'b0, victim_ff};
               ov_in = 1'b1; ol_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= NilLink; free_ff <= '0; ov_ff <= 1'b0;
         fix_free_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; free_ff <= free_in;
         ov_ff <= ov_in; fix_free_ff <= fix_free_in;
      end
      op_ff <= op_in; val_ff <= val_in; pos_ff <= pos_in; prev_ff <= prev_in;
      cur_ff <= cur_in; n_ff <= n_in; cnt_ff <= cnt_in; victim_ff <= victim_in;
      os_ff <= os_in; oe_ff <= oe_in; oc_ff <= oc_in; ol_ff <= ol_in;
   end

   assign busy = (state_ff != S_IDLE) || ov_ff;
   assign rsp_valid = ov_ff;
   assign rsp_status = os_ff;
   assign rsp_element = oe_ff;
   assign rsp_removed_count = oc_ff;
   assign rsp_last = ol_ff;
endmodule
`default_nettype wire

// ===== rtl/core/pll_checker.sv =====
// Port checker for the linked list engine, bound to the top level.
`default_nettype none
module pll_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic [15:0] rsp_element,
   input wire logic       rsp_last
);
   import pll_pkg::*;
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside busy");
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy) else $error("busy after last");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("item not taken");
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_element == '0)
      else $error("bad error result");
endmodule

bind pooled_linked_list_engine_unit pll_checker u_chk (.*);
`default_nettype wire
